// ----- design/fdr_pkg.sv -----
// Package for the dielectric Fresnel reflectance pipeline.
// Holds the fixed-point widths and constants used by the top level.
// No dependencies.
`default_nettype none

package fdr_pkg;

  // Input and output field widths
  localparam int unsigned COS_W   = 16;  // Q1.15 cosine
  localparam int unsigned INDEX_W = 16;  // Q4.12 index
  localparam int unsigned REFL_W  = 17;  // Q1.16 reflectance

  // Internal widths
  localparam int unsigned CSQ_W   = 31;  // ci^2 and sin^2, Q2.30, at most 2^30
  localparam int unsigned NSQ_W   = 32;  // index squared
  localparam int unsigned PROD_W  = 62;  // index^2 * sin^2 and nt^2 << 30
  localparam int unsigned COS2_W  = 33;  // cos^2 of refracted angle, Q.32, at most 2^32
  localparam int unsigned NUM1_W  = 64;  // numerator of cos^2 division
  localparam int unsigned ROOT_W  = 17;  // Q1.16 cosine, at most 65536
  localparam int unsigned AMP_W   = 33;  // index times cosine, Q5.28
  localparam int unsigned SUM_W   = 34;  // sum of two amplitudes
  localparam int unsigned NUM2_W  = 50;  // (diff << 16) + sum/2
  localparam int unsigned RATIO_W = 17;  // Q1.16 ratio

  localparam logic [CSQ_W-1:0]  ONE_Q30 = 31'h4000_0000;
  localparam logic [REFL_W-1:0] ONE_Q16 = 17'h1_0000;

endpackage

`default_nettype wire

// ----- design/fdr_div_pipe.sv -----
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Carries a valid bit and a sideband word alongside each item. No package use.
`default_nettype none

module fdr_div_pipe #(
  parameter int unsigned NUM_W  = 64,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned QUO_W  = 33,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [QUO_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  // Stage registers: partial remainder, numerator bits still to come
  // shifted together with the quotient bits already found
  logic [DEN_W-1:0]  rem  [QUO_W];
  logic [QUO_W-1:0]  low  [QUO_W];
  logic [DEN_W-1:0]  den  [QUO_W];
  logic [SIDE_W-1:0] side [QUO_W];
  logic              vld  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0]  rem_in;
    logic [QUO_W-1:0]  low_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [DEN_W:0]    trial;
    logic              fits;

    if (k == 0) begin : g_first
      // upper numerator bits are known to be below the divisor
      assign rem_in  = DEN_W'(in_num >> QUO_W);
      assign low_in  = in_num[QUO_W-1:0];
      assign den_in  = in_den;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign low_in  = low[k-1];
      assign den_in  = den[k-1];
      assign side_in = side[k-1];
      assign vld_in  = vld[k-1];
    end

    // bring down next numerator bit and try a subtract
    assign trial = {rem_in, low_in[QUO_W-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in;
      end
      rem[k]  <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      low[k]  <= {low_in[QUO_W-2:0], fits};
      den[k]  <= den_in;
      side[k] <= side_in;
    end
  end

  assign out_vld  = vld[QUO_W-1];
  assign out_quo  = low[QUO_W-1];
  assign out_side = side[QUO_W-1];

endmodule

`default_nettype wire

// ----- design/fdr_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit per register stage (floor result).
// Carries a valid bit and a sideband word alongside each item. No package use.
`default_nettype none

module fdr_sqrt_pipe #(
  parameter int unsigned VAL_W  = 33,
  parameter int unsigned ROOT_W = 17,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [VAL_W-1:0]  in_val,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [ROOT_W-1:0]      out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int unsigned TW = 2 * ROOT_W + 1;

  // Stage registers: remainder v - root^2 and partial root
  logic [VAL_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [SIDE_W-1:0] side [ROOT_W];
  logic              vld  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned B = ROOT_W - 1 - k;
    logic [VAL_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [TW-1:0]     trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign rem_in  = in_val;
      assign root_in = '0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
      assign side_in = side[k-1];
      assign vld_in  = vld[k-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
    assign fits  = TW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in;
      end
      rem[k]  <= fits ? VAL_W'(TW'(rem_in) - trial) : rem_in;
      root[k] <= fits ? (root_in | (ROOT_W'(1) << B)) : root_in;
      side[k] <= side_in;
    end
  end

  assign out_vld  = vld[ROOT_W-1];
  assign out_root = root[ROOT_W-1];
  assign out_side = side[ROOT_W-1];

endmodule

`default_nettype wire

// ----- design/dielectric_fresnel_reflectance.sv -----
// Top level of the unpolarized dielectric Fresnel reflectance pipeline.
// Uses fdr_pkg, fdr_div_pipe and fdr_sqrt_pipe.
//
//  channel  | handshake     | payload
//  ---------+---------------+--------------------------------------------------
//  input    | start / busy  | cos_incident, index_incident, index_transmitted
//  result   | done          | reflectance, total_reflection
//
// One item may enter every cycle; busy is always low. Each result passes
// through the 33-stage cos^2 divider, the 17-stage square root and the
// 17-stage ratio dividers plus eight arithmetic stages. Reset clears all
// valid bits at once; results are strobed for one cycle and the pipeline
// never stalls.
`default_nettype none

module dielectric_fresnel_reflectance
  import fdr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COS_W-1:0]   cos_incident,
  input  wire logic [INDEX_W-1:0]        index_incident,
  input  wire logic [INDEX_W-1:0]        index_transmitted,
  output logic                           done,
  output logic [REFL_W-1:0]              reflectance,
  output logic                           total_reflection
);

  localparam int unsigned SIDE1_W = 1 + COS_W + 2 * INDEX_W;
  localparam int unsigned LATENCY = 4 + COS2_W + ROOT_W + 2 + RATIO_W + 2;

  assign busy = 1'b0;

  // Stage 0: fold inside rays to outside, take cosine magnitude
  logic               vld0;
  logic [COS_W-1:0]   ci0;
  logic [INDEX_W-1:0] ni0, nt0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= start;
    end
    ci0 <= cos_incident[COS_W-1] ? (~$unsigned(cos_incident) + 16'd1)
                                 : $unsigned(cos_incident);
    ni0 <= cos_incident[COS_W-1] ? index_transmitted : index_incident;
    nt0 <= cos_incident[COS_W-1] ? index_incident : index_transmitted;
  end

  // Stage 1: squares
  logic [31:0]        ci_sq;
  logic [NSQ_W-1:0]   ni_sq, nt_sq;
  logic               vld1;
  logic [CSQ_W-1:0]   ci2_1;
  logic [NSQ_W-1:0]   ni2_1, nt2_1;
  logic [COS_W-1:0]   ci1;
  logic [INDEX_W-1:0] ni1, nt1;

  assign ci_sq = ci0 * ci0;
  assign ni_sq = ni0 * ni0;
  assign nt_sq = nt0 * nt0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= vld0;
    end
    ci2_1 <= ci_sq[CSQ_W-1:0];
    ni2_1 <= ni_sq;
    nt2_1 <= nt_sq;
    ci1   <= ci0;
    ni1   <= ni0;
    nt1   <= nt0;
  end

  // Stage 2: ni^2 * sin^2 against nt^2 scaled to Q2.30
  logic [CSQ_W-1:0]   s2;
  logic [62:0]        lhs_full;
  logic               vld2;
  logic [PROD_W-1:0]  lhs2, rhs2;
  logic [NSQ_W-1:0]   nt2_2;
  logic [COS_W-1:0]   ci2;
  logic [INDEX_W-1:0] ni2, nt2;

  assign s2       = ONE_Q30 - ci2_1;
  assign lhs_full = ni2_1 * s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    lhs2  <= lhs_full[PROD_W-1:0];
    rhs2  <= {nt2_1, 30'd0};
    nt2_2 <= nt2_1;
    ci2   <= ci1;
    ni2   <= ni1;
    nt2   <= nt1;
  end

  // Stage 3: total reflection test and cos^2 numerator
  logic [PROD_W-1:0]  gap;
  logic               vld3, tir3;
  logic [NUM1_W-1:0]  num3;
  logic [NSQ_W-1:0]   den3;
  logic [COS_W-1:0]   ci3;
  logic [INDEX_W-1:0] ni3, nt3;

  assign gap = rhs2 - lhs2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    tir3 <= lhs2 >= rhs2;
    num3 <= (lhs2 >= rhs2) ? '0 : {gap, 2'b00};
    den3 <= nt2_2;
    ci3  <= ci2;
    ni3  <= ni2;
    nt3  <= nt2;
  end

  // cos^2 of refracted angle
  logic               vld_d1;
  logic [COS2_W-1:0]  cos2_d1;
  logic [SIDE1_W-1:0] side_d1;

  fdr_div_pipe #(
    .NUM_W (NUM1_W),
    .DEN_W (NSQ_W),
    .QUO_W (COS2_W),
    .SIDE_W(SIDE1_W)
  ) u_cos2_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (vld3),
    .in_num  (num3),
    .in_den  (den3),
    .in_side ({tir3, ci3, ni3, nt3}),
    .out_vld (vld_d1),
    .out_quo (cos2_d1),
    .out_side(side_d1)
  );

  // cosine of refracted angle
  logic               vld_sq;
  logic [ROOT_W-1:0]  cos_t;
  logic [SIDE1_W-1:0] side_sq;

  fdr_sqrt_pipe #(
    .VAL_W (COS2_W),
    .ROOT_W(ROOT_W),
    .SIDE_W(SIDE1_W)
  ) u_cos_sqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (vld_d1),
    .in_val  (cos2_d1),
    .in_side (side_d1),
    .out_vld (vld_sq),
    .out_root(cos_t),
    .out_side(side_sq)
  );

  // Stage P: index times cosine products
  logic               tir_s;
  logic [COS_W-1:0]   ci_s;
  logic [INDEX_W-1:0] ni_s, nt_s;
  logic [ROOT_W-1:0]  cos_i;
  logic [AMP_W-1:0]   p_par_c, q_par_c, p_perp_c, q_perp_c;
  logic               vld_p, tir_p;
  logic [AMP_W-1:0]   p_par, q_par, p_perp, q_perp;

  assign {tir_s, ci_s, ni_s, nt_s} = side_sq;
  assign cos_i    = {ci_s, 1'b0};
  assign p_par_c  = nt_s * cos_i;
  assign q_par_c  = ni_s * cos_t;
  assign p_perp_c = ni_s * cos_i;
  assign q_perp_c = nt_s * cos_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else begin
      vld_p <= vld_sq;
    end
    tir_p  <= tir_s;
    p_par  <= p_par_c;
    q_par  <= q_par_c;
    p_perp <= p_perp_c;
    q_perp <= q_perp_c;
  end

  // Stage D: sums, differences and rounded ratio numerators
  logic [SUM_W-1:0]  sum_par, sum_perp;
  logic [AMP_W-1:0]  dif_par, dif_perp;
  logic              vld_n, tir_n, zero_par, zero_perp;
  logic [NUM2_W-1:0] num_par, num_perp;
  logic [SUM_W-1:0]  den_par, den_perp;

  assign sum_par  = {1'b0, p_par} + {1'b0, q_par};
  assign sum_perp = {1'b0, p_perp} + {1'b0, q_perp};
  assign dif_par  = (p_par > q_par) ? (p_par - q_par) : (q_par - p_par);
  assign dif_perp = (p_perp > q_perp) ? (p_perp - q_perp) : (q_perp - p_perp);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_n <= 1'b0;
    end else begin
      vld_n <= vld_p;
    end
    tir_n     <= tir_p;
    zero_par  <= sum_par == '0;
    zero_perp <= sum_perp == '0;
    num_par   <= NUM2_W'({dif_par, 16'd0}) + NUM2_W'(sum_par[SUM_W-1:1]);
    num_perp  <= NUM2_W'({dif_perp, 16'd0}) + NUM2_W'(sum_perp[SUM_W-1:1]);
    den_par   <= sum_par;
    den_perp  <= sum_perp;
  end

  // amplitude ratio dividers
  logic               vld_rp, vld_rs;
  logic [RATIO_W-1:0] quo_par, quo_perp;
  logic [1:0]         side_rp;
  logic               side_rs;

  fdr_div_pipe #(
    .NUM_W (NUM2_W),
    .DEN_W (SUM_W),
    .QUO_W (RATIO_W),
    .SIDE_W(2)
  ) u_par_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (vld_n),
    .in_num  (num_par),
    .in_den  (den_par),
    .in_side ({tir_n, zero_par}),
    .out_vld (vld_rp),
    .out_quo (quo_par),
    .out_side(side_rp)
  );

  fdr_div_pipe #(
    .NUM_W (NUM2_W),
    .DEN_W (SUM_W),
    .QUO_W (RATIO_W),
    .SIDE_W(1)
  ) u_perp_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (vld_n),
    .in_num  (num_perp),
    .in_den  (den_perp),
    .in_side (zero_perp),
    .out_vld (vld_rs),
    .out_quo (quo_perp),
    .out_side(side_rs)
  );

  // Stage Q: squared ratios, a zero sum counts as ratio one
  logic [RATIO_W-1:0] r_par, r_perp;
  logic [33:0]        sq_par, sq_perp;
  logic               vld_q, tir_q;
  logic [REFL_W-1:0]  rsq_par, rsq_perp;

  assign r_par   = side_rp[0] ? ONE_Q16 : quo_par;
  assign r_perp  = side_rs ? ONE_Q16 : quo_perp;
  assign sq_par  = r_par * r_par + 34'd32768;
  assign sq_perp = r_perp * r_perp + 34'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_rp & vld_rs;
    end
    tir_q    <= side_rp[1];
    rsq_par  <= sq_par[32:16];
    rsq_perp <= sq_perp[32:16];
  end

  // Output stage: average with rounding, clamp, total reflection override
  logic [REFL_W:0]   tot;
  logic [REFL_W-1:0] avg;

  assign tot = {1'b0, rsq_par} + {1'b0, rsq_perp} + 18'd1;
  assign avg = tot[REFL_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_q;
    end
    total_reflection <= tir_q;
    if (tir_q || avg > ONE_Q16) begin
      reflectance <= ONE_Q16;
    end else begin
      reflectance <= avg;
    end
  end

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("item did not complete at the expected latency");

  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching item");

  a_range : assert property (@(posedge clk) disable iff (rst)
    done |-> reflectance <= ONE_Q16)
    else $error("reflectance above one");

  a_tir_one : assert property (@(posedge clk) disable iff (rst)
    done && total_reflection |-> reflectance == ONE_Q16)
    else $error("total reflection without unit reflectance");
`endif

endmodule

`default_nettype wire
